FILE: hw/rtl/dlms_pkg.sv
// Shared types and constants for the dual LED matrix shift scanner.
`timescale 1ns / 1ps

package dlms_pkg;

  // Fixed field widths of the stream items
  localparam int unsigned RowWordW  = 16;
  localparam int unsigned RowLinesW = 5;
  localparam int unsigned FetchW    = 3;
  localparam int unsigned InDataW   = 2 * RowWordW;
  localparam int unsigned OutDataW  = 16;

  localparam logic [RowWordW-1:0] BlankReset = 16'hFFFF;

  // Item kinds carried in tuser
  typedef enum logic {
    CMD_TICK      = 1'b0,
    CMD_HOLD_DONE = 1'b1
  } cmd_e;

  // Per-bit sequencing of the pin driver
  typedef enum logic [1:0] {
    PH_SET_DATA = 2'd0,
    PH_CLOCK    = 2'd1,
    PH_LATCH_HI = 2'd2,
    PH_LATCH_LO = 2'd3
  } phase_e;

  // Pin levels driven toward the matrices
  typedef struct packed {
    logic [RowLinesW-1:0] row_select;
    logic                 latch_strobe;
    logic                 shift_clock;
    logic                 serial_data_b;
    logic                 serial_data_a;
  } dlms_pins_t;

  // Result of one step of the scanner
  typedef struct packed {
    logic [FetchW-1:0] fetch_row;
    logic              shifting;
    dlms_pins_t        pins;
  } dlms_status_t;

endpackage

FILE: hw/rtl/dlms_core.sv
// Scan state machine: column word shifting, latch strobe and row stepping.
`timescale 1ns / 1ps

module dlms_core import dlms_pkg::*; #(
  parameter int unsigned ROWS      = 5,
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,        // one item is processed this cycle
  input  cmd_e                cmd_i,
  input  logic [RowWordW-1:0] row_data_a_i,
  input  logic [RowWordW-1:0] row_data_b_i,
  input  logic [RowWordW-1:0] blank_pattern_i,
  output dlms_status_t        status_d_o     // levels after this item
);

  localparam int unsigned SW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned CW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [SW-1:0] LastRow = SW'(ROWS - 1);
  localparam logic [CW-1:0] LastBit = CW'(WORD_BITS - 1);
  // Reset blank word, fitted to the shift length like the register value
  localparam logic [WORD_BITS+RowWordW-1:0] BlankExt = {{WORD_BITS{1'b0}}, BlankReset};
  localparam logic [WORD_BITS-1:0]          BlankInit = BlankExt[WORD_BITS-1:0];

  phase_e                 phase_q, phase_d;
  logic                   clk_lvl_q, clk_lvl_d;
  logic [CW-1:0]          bit_cnt_q, bit_cnt_d;
  logic [WORD_BITS-1:0]   word_a_q, word_a_d, word_b_q, word_b_d;
  logic [WORD_BITS-1:0]   blank_a_q, blank_a_d, blank_b_q, blank_b_d;
  logic                   blanking_q, blanking_d;
  logic [SW-1:0]          scan_row_q, scan_row_d;
  logic [SW-1:0]          load_row_q, load_row_d;
  logic                   running_q, running_d;
  dlms_pins_t             pins_q, pins_d;

  logic [WORD_BITS+RowWordW-1:0] ext_a, ext_b, ext_blank;
  logic [WORD_BITS-1:0]          in_a_w, in_b_w, blank_w;
  logic [RowLinesW-1:0]          row_dec;
  logic [SW+FetchW-1:0]          load_ext;
  logic                          tick, hold;

  // Fit the 16-bit words to the shift length
  assign ext_a     = {{WORD_BITS{1'b0}}, row_data_a_i};
  assign ext_b     = {{WORD_BITS{1'b0}}, row_data_b_i};
  assign ext_blank = {{WORD_BITS{1'b0}}, blank_pattern_i};
  assign in_a_w    = ext_a[WORD_BITS-1:0];
  assign in_b_w    = ext_b[WORD_BITS-1:0];
  assign blank_w   = ext_blank[WORD_BITS-1:0];

  // One-hot row decode; rows beyond the pins drive nothing
  always_comb begin
    for (int i = 0; i < RowLinesW; i++) begin
      row_dec[i] = (32'(scan_row_q) == 32'(i));
    end
  end

  assign tick = step_i && (cmd_i == CMD_TICK) && running_q;
  assign hold = step_i && (cmd_i == CMD_HOLD_DONE) && !running_q;

  // Next state
  always_comb begin
    phase_d    = phase_q;
    clk_lvl_d  = clk_lvl_q;
    bit_cnt_d  = bit_cnt_q;
    word_a_d   = word_a_q;
    word_b_d   = word_b_q;
    blank_a_d  = blank_a_q;
    blank_b_d  = blank_b_q;
    blanking_d = blanking_q;
    scan_row_d = scan_row_q;
    load_row_d = load_row_q;
    running_d  = running_q;
    pins_d     = pins_q;

    if (hold) begin
      word_a_d   = in_a_w;
      word_b_d   = in_b_w;
      load_row_d = (load_row_q == LastRow) ? '0 : load_row_q + 1'b1;
      running_d  = 1'b1;
    end

    if (tick) begin
      unique case (phase_q)
        PH_SET_DATA: begin
          if (bit_cnt_q == '0) begin
            clk_lvl_d         = 1'b0;
            pins_d.row_select = row_dec;
          end
          pins_d.serial_data_a = blanking_q ? blank_a_q[WORD_BITS-1] : word_a_q[WORD_BITS-1];
          pins_d.serial_data_b = blanking_q ? blank_b_q[WORD_BITS-1] : word_b_q[WORD_BITS-1];
          phase_d = PH_CLOCK;
        end
        PH_CLOCK: begin
          if (!clk_lvl_q) begin
            pins_d.shift_clock = 1'b1;
            clk_lvl_d          = 1'b1;
          end else begin
            pins_d.shift_clock = 1'b0;
            clk_lvl_d          = 1'b0;
            if (blanking_q) begin
              blank_a_d = blank_a_q << 1;
              blank_b_d = blank_b_q << 1;
            end else begin
              word_a_d = word_a_q << 1;
              word_b_d = word_b_q << 1;
            end
            if (bit_cnt_q == LastBit) begin
              bit_cnt_d = '0;
              phase_d   = PH_LATCH_HI;
            end else begin
              bit_cnt_d = bit_cnt_q + 1'b1;
              phase_d   = PH_SET_DATA;
            end
          end
        end
        PH_LATCH_HI: begin
          pins_d.latch_strobe = 1'b1;
          phase_d             = PH_LATCH_LO;
        end
        PH_LATCH_LO: begin
          pins_d.latch_strobe = 1'b0;
          phase_d             = PH_SET_DATA;
          blank_a_d           = blank_w;
          blank_b_d           = blank_w;
          if (blanking_q) begin
            scan_row_d = (scan_row_q == LastRow) ? '0 : scan_row_q + 1'b1;
            blanking_d = 1'b0;
          end else begin
            blanking_d = 1'b1;
            running_d  = 1'b0;
          end
        end
        default: phase_d = PH_SET_DATA;
      endcase
    end
  end

  // Outputs: levels after the item
  assign load_ext = {{FetchW{1'b0}}, load_row_d};
  always_comb begin
    status_d_o.pins      = pins_d;
    status_d_o.shifting  = running_d;
    status_d_o.fetch_row = load_ext[FetchW-1:0];
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SET_DATA;
      clk_lvl_q  <= 1'b0;
      bit_cnt_q  <= '0;
      word_a_q   <= '0;
      word_b_q   <= '0;
      blank_a_q  <= BlankInit;
      blank_b_q  <= BlankInit;
      blanking_q <= 1'b0;
      scan_row_q <= '0;
      load_row_q <= '0;
      running_q  <= 1'b1;
      pins_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      clk_lvl_q  <= clk_lvl_d;
      bit_cnt_q  <= bit_cnt_d;
      word_a_q   <= word_a_d;
      word_b_q   <= word_b_d;
      blank_a_q  <= blank_a_d;
      blank_b_q  <= blank_b_d;
      blanking_q <= blanking_d;
      scan_row_q <= scan_row_d;
      load_row_q <= load_row_d;
      running_q  <= running_d;
      pins_q     <= pins_d;
    end
  end

endmodule

FILE: hw/rtl/dual_led_matrix_shift_scanner.sv
// Top level of the dual LED matrix shift scanner: stream stages around the scan core.
`timescale 1ns / 1ps

// Usage
// - Slave stream: one item per handshake. tuser = cmd (0 tick, 1 hold done);
//   tdata carries the next row words of both matrices for hold-done items.
// - Master stream: exactly one item per input item, the pin levels after it,
//   plus the shifting flag and the row index the next hold-done should carry.
// - Config channel: cfg_data_i writes the blanking column word; always ready.
//   Write it only while no item is in flight.
// - Path: an accepted item lands in the input register; once the output
//   register has space, the scan logic puts its result there.
// - Throughput: one item per cycle unless the output stalls; the scan state
//   machine steps once per item, so the rate is set by its combinational logic.
// - Stall: when m_axis_tready is low the result holds; the input register
//   still takes one more item, then s_axis_tready drops until space frees.
// - Reset: all pins low, shifting on, row 0, blank word 0xFFFF; the first
//   frame shifts zero words, then the block pauses for a hold-done item.
module dual_led_matrix_shift_scanner import dlms_pkg::*; #(
  parameter int unsigned ROWS      = 5,
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [15:0] row_data_a, [31:16] row_data_b
  input  logic                s_axis_tuser,   // [0] cmd
  // Result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [0] serial_data_a, [1] serial_data_b,
                                              // [2] shift_clock, [3] latch_strobe,
                                              // [8:4] row_select, [9] shifting,
                                              // [12:10] fetch_row, [15:13] zero
  // Blank pattern register
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [RowWordW-1:0] cfg_data_i
);

  localparam int unsigned StatusW = $bits(dlms_status_t);

  logic                in_valid_q;
  cmd_e                cmd_q;
  logic [RowWordW-1:0] data_a_q, data_b_q;
  logic                out_valid_q;
  dlms_status_t        out_q;
  dlms_status_t        status_d;
  logic [RowWordW-1:0] blank_q;
  logic                out_free, advance;

  // Pipeline flow control
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign cfg_ready_o   = 1'b1;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_q <= BlankReset;
    end else if (cfg_valid_i) begin
      blank_q <= cfg_data_i;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q    <= cmd_e'(s_axis_tuser);
      data_a_q <= s_axis_tdata[RowWordW-1:0];
      data_b_q <= s_axis_tdata[InDataW-1:RowWordW];
    end
  end

  dlms_core #(
    .ROWS      (ROWS),
    .WORD_BITS (WORD_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .cmd_i           (cmd_q),
    .row_data_a_i    (data_a_q),
    .row_data_b_i    (data_b_q),
    .blank_pattern_i (blank_q),
    .status_d_o      (status_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-StatusW){1'b0}}, out_q};

endmodule

FILE: tb/sv/tb.sv
// Self-checking bench for the dual LED matrix shift scanner: predicts pin levels per item.
`timescale 1ns / 1ps

module tb;
  import dlms_pkg::*;

  localparam int unsigned NumRows    = 5;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldOffLen = 300;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // [15:0] row_data_a, [31:16] row_data_b
  logic                s_axis_tuser;   // [0] cmd
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // [0] data a, [1] data b, [2] clock, [3] latch,
                                       // [8:4] rows, [9] shifting, [12:10] fetch_row
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [RowWordW-1:0] cfg_data_i;

  dual_led_matrix_shift_scanner dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Scanner mirror state
  logic [RowWordW-1:0] blank_reg_q;
  logic [RowWordW-1:0] col_a, col_b, blank_col_a, blank_col_b;
  phase_e              step_ph;
  logic                clk_high;
  int unsigned         bit_idx;
  logic                blank_frame;
  int unsigned         row_idx;
  int unsigned         fetch_idx;
  logic                scanning;
  dlms_pins_t          pins_now;

  dlms_status_t scan_status_q[$];
  int unsigned  mismatch_cnt;
  int unsigned  cycle_cnt;
  bit           steady;    // no idling on either side
  bit           hold_req;  // ask the receiver for one long hold-off

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Mirror of the scanner, advanced once per accepted item
  task automatic step_scanner(input cmd_e cmd, input logic [RowWordW-1:0] data_a,
                              input logic [RowWordW-1:0] data_b);
    dlms_status_t st;
    if (cmd == CMD_TICK) begin
      if (scanning) begin
        case (step_ph)
          PH_SET_DATA: begin
            if (bit_idx == 0) begin
              clk_high = 1'b0;
              pins_now.row_select = (row_idx < RowLinesW) ? RowLinesW'(1 << row_idx) : '0;
            end
            pins_now.serial_data_a = blank_frame ? blank_col_a[RowWordW-1] : col_a[RowWordW-1];
            pins_now.serial_data_b = blank_frame ? blank_col_b[RowWordW-1] : col_b[RowWordW-1];
            step_ph = PH_CLOCK;
          end
          PH_CLOCK: begin
            if (!clk_high) begin
              pins_now.shift_clock = 1'b1;
              clk_high = 1'b1;
            end else begin
              pins_now.shift_clock = 1'b0;
              clk_high = 1'b0;
              if (blank_frame) begin
                blank_col_a = blank_col_a << 1;
                blank_col_b = blank_col_b << 1;
              end else begin
                col_a = col_a << 1;
                col_b = col_b << 1;
              end
              bit_idx++;
              if (bit_idx >= RowWordW) begin
                bit_idx = 0;
                step_ph = PH_LATCH_HI;
              end else begin
                step_ph = PH_SET_DATA;
              end
            end
          end
          PH_LATCH_HI: begin
            pins_now.latch_strobe = 1'b1;
            step_ph = PH_LATCH_LO;
          end
          default: begin
            // frame done: blanks reload, row advances after a blanking frame
            pins_now.latch_strobe = 1'b0;
            step_ph = PH_SET_DATA;
            blank_col_a = blank_reg_q;
            blank_col_b = blank_reg_q;
            if (blank_frame) begin
              row_idx = (row_idx + 1) % NumRows;
              blank_frame = 1'b0;
            end else begin
              blank_frame = 1'b1;
              scanning = 1'b0;
            end
          end
        endcase
      end
    end else if (!scanning) begin
      col_a = data_a;
      col_b = data_b;
      fetch_idx = (fetch_idx + 1) % NumRows;
      scanning = 1'b1;
    end
    st.pins      = pins_now;
    st.shifting  = scanning;
    st.fetch_row = FetchW'(fetch_idx);
    scan_status_q.push_back(st);
  endtask

  // Send one item, with random gaps before it
  task automatic send_item(input cmd_e cmd, input logic [RowWordW-1:0] data_a,
                           input logic [RowWordW-1:0] data_b);
    if (!steady) begin
      while ($urandom_range(99) < 15) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data_b, data_a};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    step_scanner(cmd, data_a, data_b);
  endtask

  // Stop sending and let every outstanding result drain
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (scan_status_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Blank pattern write; only called with nothing in flight
  task automatic write_blank(input logic [RowWordW-1:0] pattern);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= pattern;
    do @(posedge clk_i); while (!cfg_ready_o);
    blank_reg_q = pattern;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_until_paused();
    while (scanning) send_item(CMD_TICK, 16'(($urandom)), 16'($urandom));
  endtask

  // Hold-done while running is dropped, reset frame shifts, ticks while paused do nothing
  task automatic test_reset_frame();
    send_item(CMD_HOLD_DONE, 16'hFFFF, 16'h0000);
    send_item(CMD_HOLD_DONE, 16'h0000, 16'hFFFF);
    run_until_paused();
    repeat (3) send_item(CMD_TICK, 16'hFFFF, 16'hFFFF);
  endtask

  // Full rows with extreme blank patterns and row words
  task automatic test_row_cycles();
    logic [RowWordW-1:0] blanks [5];
    logic [RowWordW-1:0] words_a [5];
    logic [RowWordW-1:0] words_b [5];
    blanks  = '{16'h0000, 16'hFFFF, 16'h8000, 16'h5555, 16'h0001};
    words_a = '{16'hFFFF, 16'h0000, 16'h8000, 16'hAAAA, 16'h1234};
    words_b = '{16'h0000, 16'hFFFF, 16'h0001, 16'h5555, 16'hFEDC};
    for (int i = 0; i < 5; i++) begin
      wait_drained();
      write_blank(blanks[i]);
      send_item(CMD_HOLD_DONE, words_a[i], words_b[i]);
      run_until_paused();
    end
  endtask

  // Mostly well-formed rows with random words, plus stray commands
  task automatic test_random_scan();
    cmd_e                cmd;
    logic [RowWordW-1:0] data_a, data_b;
    for (int n = 0; n < 950; n++) begin
      steady = (n >= 250 && n < 450);
      if (n == 600) hold_req = 1'b1;
      if (n == 750) wait_drained();
      if (n == 300 || n == 850) begin
        wait_drained();
        write_blank(16'($urandom));
      end
      if (scanning)
        cmd = ($urandom_range(99) < 3) ? CMD_HOLD_DONE : CMD_TICK;
      else
        cmd = ($urandom_range(99) < 20) ? CMD_TICK : CMD_HOLD_DONE;
      data_a = 16'($urandom);
      data_b = 16'($urandom);
      if ($urandom_range(9) == 0) data_a = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      if ($urandom_range(9) == 0) data_b = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      send_item(cmd, data_a, data_b);
    end
    steady = 1'b0;
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned hold_cnt;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        hold_cnt = 0;
        while (hold_cnt < HoldOffLen) begin
          @(posedge clk_i);
          hold_cnt++;
        end
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 15);
      end
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    dlms_status_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = dlms_status_t'(m_axis_tdata[12:0]);
      if (scan_status_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %0h", $time, m_axis_tdata);
        mismatch_cnt++;
      end else begin
        want = scan_status_q.pop_front();
        check_field("serial_data_a", want.pins.serial_data_a, got.pins.serial_data_a);
        check_field("serial_data_b", want.pins.serial_data_b, got.pins.serial_data_b);
        check_field("shift_clock", want.pins.shift_clock, got.pins.shift_clock);
        check_field("latch_strobe", want.pins.latch_strobe, got.pins.latch_strobe);
        check_field("row_select", want.pins.row_select, got.pins.row_select);
        check_field("shifting", want.shifting, got.shifting);
        check_field("fetch_row", want.fetch_row, got.fetch_row);
        check_field("pad", 0, m_axis_tdata[15:13]);
      end
    end
  end

  // Main sequence
  initial begin
    mismatch_cnt  = 0;
    steady        = 1'b0;
    hold_req      = 1'b0;
    blank_reg_q   = BlankReset;
    col_a         = '0;
    col_b         = '0;
    blank_col_a   = BlankReset;
    blank_col_b   = BlankReset;
    step_ph       = PH_SET_DATA;
    clk_high      = 1'b0;
    bit_idx       = 0;
    blank_frame   = 1'b0;
    row_idx       = 0;
    fetch_idx     = 0;
    scanning      = 1'b1;
    pins_now      = '0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_TICK;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_frame();
    test_row_cycles();
    test_random_scan();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0 && scan_status_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
